// ===== src/rsc_pkg.sv =====
// Shared types, constants and character helpers of the radix string converter.
package rsc_pkg;

	localparam int VALUE_BITS = 63;
	localparam int MAX_DIGITS = 64;

	localparam int CHAR_W   = 8;
	localparam int BASE_W   = 6;
	localparam int ADDR_W   = $clog2(MAX_DIGITS);
	localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
	localparam int BITCNT_W = $clog2(VALUE_BITS);
	localparam int PROD_W   = VALUE_BITS + BASE_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 2'd1;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UZ = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7A;
	localparam logic [BASE_W-1:0] DEC_RADIX = 6'd10;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_DECIDE,
		S_CONV,
		S_DIV,
		S_STORE,
		S_ERR,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	typedef struct packed {
		logic ok;
		logic [BASE_W-1:0] val;
	} digit_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic mul;
		logic add;
		logic conv_init;
		logic div_step;
		logic store;
		logic set_ovf;
		logic err_load;
		logic emit_load;
		logic clear_run;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic take_ok;
		logic last;
		logic err_nz;
		logic acc_zero;
		logic div_done;
		logic quot_zero;
		logic count_full;
		logic count_one;
		logic out_free;
	} sts_t;

	function automatic digit_t char_value(logic [CHAR_W-1:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = '0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d.val = BASE_W'(c - CHAR_0);
		end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
			d.val = BASE_W'(c - CHAR_UA + CHAR_W'(DEC_RADIX));
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			d.val = BASE_W'(c - CHAR_LA + CHAR_W'(DEC_RADIX));
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_RADIX) begin
			c = CHAR_0 + CHAR_W'(d);
		end else begin
			c = CHAR_UA + CHAR_W'(d) - CHAR_W'(DEC_RADIX);
		end
		return c;
	endfunction

endpackage

// ===== src/rsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/rsc_datapath.sv =====
// Datapath: config registers, accumulator, bit-serial divider, digit RAM, output register.
module rsc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rsc_pkg::cmd_t                    cmd,
	output rsc_pkg::sts_t                    sts,
	input  logic                             cfg_valid,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsc_pkg::BASE_W-1:0]       cfg_data,
	input  logic [rsc_pkg::CHAR_W-1:0]       in_char,
	input  logic                             in_last,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [rsc_pkg::CHAR_W-1:0]       out_char,
	output logic                             out_last,
	output logic [1:0]                       out_status
);

	localparam int VB = rsc_pkg::VALUE_BITS;
	localparam int BW = rsc_pkg::BASE_W;
	localparam int PW = rsc_pkg::PROD_W;
	localparam int CW = rsc_pkg::CNT_W;
	localparam int AW = rsc_pkg::ADDR_W;

	logic [BW-1:0]                    src_base_q, tgt_base_q, tbase_q;
	logic [VB-1:0]                    acc_q, val_q;
	rsc_pkg::status_t                 err_q, out_status_q;
	logic [rsc_pkg::CHAR_W-1:0]       char_q, out_char_q;
	logic                             last_q, out_valid_q, out_last_q;
	logic [PW-1:0]                    prod_q, sum;
	logic [BW-1:0]                    rem_q;
	logic [rsc_pkg::BITCNT_W-1:0]     bitcnt_q;
	logic [CW-1:0]                    count_q, cnt_dec;
	rsc_pkg::digit_t                  dig;
	logic                             bad;
	logic [BW:0]                      rem_shift, rem_sub;
	logic                             qbit;
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [BW-1:0]                    ram_wdata, ram_rdata;
	logic                             out_free;

	assign dig = rsc_pkg::char_value(char_q);
	assign bad = !dig.ok || (dig.val >= src_base_q);
	assign sum = prod_q + PW'(dig.val);

	// one restoring step per cycle, dividend MSB first
	assign rem_shift = {rem_q, val_q[VB-1]};
	assign qbit      = (rem_shift >= {1'b0, tbase_q});
	assign rem_sub   = qbit ? (rem_shift - {1'b0, tbase_q}) : rem_shift;

	assign cnt_dec   = count_q - CW'(1);
	assign out_free  = !out_valid_q || out_ready;

	assign ram_we    = cmd.store || (cmd.conv_init && acc_q == '0);
	assign ram_waddr = cmd.store ? count_q[AW-1:0] : '0;
	assign ram_wdata = cmd.store ? rem_q : '0;

	rsc_ram #(
		.WIDTH (BW),
		.DEPTH (rsc_pkg::MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= rsc_pkg::BASE_RESET;
			tgt_base_q <= rsc_pkg::BASE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == rsc_pkg::CFG_SOURCE_BASE) begin
				src_base_q <= cfg_data;
			end else if (cfg_index == rsc_pkg::CFG_TARGET_BASE) begin
				tgt_base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			err_q    <= rsc_pkg::ST_OK;
			count_q  <= '0;
			bitcnt_q <= '0;
		end else begin
			if (cmd.mul && err_q == rsc_pkg::ST_OK && bad) begin
				err_q <= rsc_pkg::ST_BAD_DIGIT;
			end
			if (cmd.add) begin
				if (|sum[PW-1:VB]) begin
					err_q <= rsc_pkg::ST_OVERFLOW;
				end else begin
					acc_q <= sum[VB-1:0];
				end
			end
			if (cmd.conv_init) begin
				bitcnt_q <= '0;
				count_q  <= (acc_q == '0) ? CW'(1) : '0;
			end
			if (cmd.div_step) begin
				bitcnt_q <= bitcnt_q + rsc_pkg::BITCNT_W'(1);
			end
			if (cmd.store) begin
				bitcnt_q <= '0;
				count_q  <= count_q + CW'(1);
			end
			if (cmd.set_ovf) begin
				err_q <= rsc_pkg::ST_OVERFLOW;
			end
			if (cmd.emit_load && !cmd.clear_run) begin
				count_q <= cnt_dec;
			end
			if (cmd.clear_run) begin
				acc_q   <= '0;
				err_q   <= rsc_pkg::ST_OK;
				count_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= in_char;
			last_q <= in_last;
		end
		if (cmd.mul) begin
			prod_q <= PW'(acc_q) * PW'(src_base_q);
		end
		if (cmd.conv_init) begin
			val_q <= acc_q;
			rem_q <= '0;
			if (tgt_base_q < rsc_pkg::BASE_MIN) begin
				tbase_q <= rsc_pkg::BASE_MIN;
			end else if (tgt_base_q > rsc_pkg::BASE_MAX) begin
				tbase_q <= rsc_pkg::BASE_MAX;
			end else begin
				tbase_q <= tgt_base_q;
			end
		end
		if (cmd.div_step) begin
			val_q <= {val_q[VB-2:0], qbit};
			rem_q <= rem_sub[BW-1:0];
		end
		if (cmd.store) begin
			rem_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.err_load || cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_load) begin
			out_char_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= err_q;
		end else if (cmd.emit_load) begin
			out_char_q   <= rsc_pkg::digit_char(ram_rdata);
			out_last_q   <= (count_q == CW'(1));
			out_status_q <= rsc_pkg::ST_OK;
		end
	end

	always_comb begin
		sts.take_ok    = (err_q == rsc_pkg::ST_OK) && !bad;
		sts.last       = last_q;
		sts.err_nz     = (err_q != rsc_pkg::ST_OK);
		sts.acc_zero   = (acc_q == '0);
		sts.div_done   = (bitcnt_q == rsc_pkg::BITCNT_W'(VB - 1));
		sts.quot_zero  = (val_q == '0);
		sts.count_full = (count_q == CW'(rsc_pkg::MAX_DIGITS - 1));
		sts.count_one  = (count_q == CW'(1));
		sts.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule

// ===== src/rsc_controller.sv =====
// Controller: sequences accumulation, division, digit storage and emission.
module rsc_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rsc_pkg::sts_t  sts,
	output rsc_pkg::cmd_t  cmd
);

	rsc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rsc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = rsc_pkg::S_MUL;
				end
			end
			rsc_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = sts.take_ok ? rsc_pkg::S_ADD : rsc_pkg::S_DECIDE;
			end
			rsc_pkg::S_ADD: begin
				cmd.add = 1'b1;
				state_d = rsc_pkg::S_DECIDE;
			end
			rsc_pkg::S_DECIDE: begin
				priority if (!sts.last) begin
					state_d = rsc_pkg::S_IDLE;
				end else if (sts.err_nz) begin
					state_d = rsc_pkg::S_ERR;
				end else begin
					state_d = rsc_pkg::S_CONV;
				end
			end
			rsc_pkg::S_CONV: begin
				cmd.conv_init = 1'b1;
				state_d = sts.acc_zero ? rsc_pkg::S_EMIT_RD : rsc_pkg::S_DIV;
			end
			rsc_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = rsc_pkg::S_STORE;
				end
			end
			rsc_pkg::S_STORE: begin
				cmd.store = 1'b1;
				priority if (sts.quot_zero) begin
					state_d = rsc_pkg::S_EMIT_RD;
				end else if (sts.count_full) begin
					// more digits than the store holds
					cmd.set_ovf = 1'b1;
					state_d     = rsc_pkg::S_ERR;
				end else begin
					state_d = rsc_pkg::S_DIV;
				end
			end
			rsc_pkg::S_ERR: begin
				if (sts.out_free) begin
					cmd.err_load  = 1'b1;
					cmd.clear_run = 1'b1;
					state_d       = rsc_pkg::S_IDLE;
				end
			end
			rsc_pkg::S_EMIT_RD: begin
				state_d = rsc_pkg::S_EMIT_LD;
			end
			rsc_pkg::S_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.count_one) begin
						cmd.clear_run = 1'b1;
						state_d       = rsc_pkg::S_IDLE;
					end else begin
						state_d = rsc_pkg::S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = rsc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/radix_string_converter_top.sv =====
// Top level of the radix string converter: ports, controller and datapath.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  tdata = char_code, tlast = is_last
//  m_*      out        m_tvalid / m_tready  tdata = out_char, tlast = out_last, tuser = status
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index = register, cfg_data = value
//
// Each character passes through the accept, multiply, add and decide states; the add
// state is skipped when its digit is refused or the run already holds an error.
// After the last character the conversion is initialised, then the one-bit-per-cycle
// restoring divider finds each output digit, which is stored; the digits are then read
// back and emitted. A run that ends in error instead loads its single error result.
// Reset clears the run state and restores both bases to 10; no RAM clearing pass.
// A stalled result holds in the output register; the controller waits before loading another.
module radix_string_converter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] char_code
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] out_char
	output logic                          m_tlast,
	output logic [1:0]                    m_tuser,   // [1:0] status
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsc_pkg::BASE_W-1:0]    cfg_data
);

	rsc_pkg::cmd_t cmd;
	rsc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rsc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_char   (m_tdata),
		.out_last   (m_tlast),
		.out_status (m_tuser)
	);

endmodule

// ===== src/rsc_checker.sv =====
// Port-level checker of the radix string converter, bound to the top level.
module rsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [7:0]                    m_tdata,
	input logic                          m_tlast,
	input logic [1:0]                    m_tuser
);

	// a stalled request keeps its valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// an error stands alone: last, with a zero character
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != rsc_pkg::ST_OK |-> m_tlast && m_tdata == 8'h00)
		else $error("malformed error result");

	a_ok_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rsc_pkg::ST_OK |->
		(m_tdata >= rsc_pkg::CHAR_0 && m_tdata <= rsc_pkg::CHAR_9) ||
		(m_tdata >= rsc_pkg::CHAR_UA && m_tdata <= rsc_pkg::CHAR_UZ))
		else $error("result character is not an upper-case digit");

	// no new character is taken while a numeral is still being emitted
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rsc_pkg::ST_OK && !m_tlast |-> !s_tready)
		else $error("input taken during emission");

endmodule

bind radix_string_converter_top rsc_checker u_chk (.*);

// ===== tb/rsc_result_checker.sv =====
// Checker for the radix string converter: predicts every result and compares it.
`timescale 1ns / 100ps
module rsc_result_checker
	import rsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] char_code
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,   // [7:0] out_char
	input  logic                 m_tlast,
	input  logic [1:0]           m_tuser,   // [1:0] status
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct {
		logic [7:0] ch;
		logic       lst;
		status_t    st;
	} out_char_t;

	logic [BASE_W-1:0]     src_radix = BASE_RESET;
	logic [BASE_W-1:0]     dst_radix = BASE_RESET;
	logic [VALUE_BITS-1:0] numeral_value = '0;
	status_t               numeral_err = ST_OK;
	out_char_t             expected_chars[$];
	out_char_t             head;
	int                    bad_results = 0;
	bit                    wrong;

	// digit value of a character, 8'hFF when it is no digit at all
	function automatic logic [7:0] digit_of(logic [7:0] c);
		if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
		if (c >= CHAR_UA && c <= CHAR_UZ) return c - CHAR_UA + 8'(DEC_RADIX);
		if (c >= CHAR_LA && c <= CHAR_LZ) return c - CHAR_LA + 8'(DEC_RADIX);
		return 8'hFF;
	endfunction

	task automatic push_char(logic [7:0] ch, logic lst, status_t st);
		out_char_t item;
		item.ch  = ch;
		item.lst = lst;
		item.st  = st;
		expected_chars.insert(expected_chars.size(), item);
	endtask

	task automatic absorb_char(logic [7:0] c, logic last);
		logic [7:0]        d;
		logic [63:0]       lim;
		logic [63:0]       v;
		logic [BASE_W-1:0] radix;
		logic [BASE_W-1:0] digits [MAX_DIGITS];
		int                n;
		bit                too_long;
		if (numeral_err == ST_OK) begin
			d = digit_of(c);
			if (d >= 8'(src_radix)) begin
				numeral_err = ST_BAD_DIGIT;
			end else begin
				// radix is non-zero here since the digit is below it
				lim = (VALUE_MAX - 64'(d)) / 64'(src_radix);
				if (64'(numeral_value) > lim) begin
					numeral_err = ST_OVERFLOW;
				end else begin
					numeral_value = VALUE_BITS'(64'(numeral_value) * 64'(src_radix) + 64'(d));
				end
			end
		end
		if (!last) return;

		if (numeral_err != ST_OK) begin
			push_char(8'h00, 1'b1, numeral_err);
		end else begin
			radix = (dst_radix < BASE_MIN) ? BASE_MIN :
				(dst_radix > BASE_MAX) ? BASE_MAX : dst_radix;
			v = 64'(numeral_value);
			n = 0;
			too_long = 1'b0;
			if (v == 0) begin
				digits[0] = '0;
				n = 1;
			end
			while (v != 0 && !too_long) begin
				if (n >= MAX_DIGITS) begin
					too_long = 1'b1;
				end else begin
					digits[n] = BASE_W'(v % 64'(radix));
					n++;
					v = v / 64'(radix);
				end
			end
			if (too_long) begin
				push_char(8'h00, 1'b1, ST_OVERFLOW);
			end else begin
				for (int k = n - 1; k >= 0; k--) begin
					push_char(8'(digits[k]) + ((digits[k] < DEC_RADIX) ? CHAR_0 :
						CHAR_UA - 8'(DEC_RADIX)), k == 0, ST_OK);
				end
			end
		end
		numeral_value = '0;
		numeral_err = ST_OK;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_radix = BASE_RESET;
			dst_radix = BASE_RESET;
			numeral_value = '0;
			numeral_err = ST_OK;
			expected_chars.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected result: expected none, got char %h last %b status %0d",
						$time, m_tdata, m_tlast, m_tuser);
					bad_results++;
				end else begin
					head = expected_chars.pop_front();
					wrong = 1'b0;
					if (m_tdata !== head.ch) begin
						$display("%0t: out_char expected %h got %h", $time, head.ch, m_tdata);
						wrong = 1'b1;
					end
					if (m_tlast !== head.lst) begin
						$display("%0t: out_last expected %b got %b", $time, head.lst, m_tlast);
						wrong = 1'b1;
					end
					if (m_tuser !== head.st) begin
						$display("%0t: status expected %0d got %0d", $time, head.st, m_tuser);
						wrong = 1'b1;
					end
					if (wrong) bad_results++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOURCE_BASE: src_radix = cfg_data;
					CFG_TARGET_BASE: dst_radix = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) absorb_char(s_tdata, s_tlast);
			outstanding <= expected_chars.size();
		end
		mismatches <= bad_results;
	end

endmodule

// ===== tb/tb_radix_string_converter_top.sv =====
// Testbench top for the radix string converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_radix_string_converter_top;
	import rsc_pkg::*;

	localparam int QUIET_LIMIT     = 20000;
	localparam int HOLD_CYCLES     = 600;
	localparam int SETTLE_CYCLES   = 16;
	localparam int CHARS_PER_PHASE = 26;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] char_code
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [7:0] out_char
	logic                 m_tlast;
	logic [1:0]           m_tuser;   // [1:0] status
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BASE_W-1:0]    cfg_data;
	int                   mismatches;
	int                   outstanding;

	bit                idle_on = 1'b1;
	bit                hold_req = 1'b0;
	int                hold_left = 0;
	int                quiet = 0;
	logic [BASE_W-1:0] cur_src = BASE_RESET;

	radix_string_converter_top uut (.*);
	rsc_result_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic set_bases(logic [BASE_W-1:0] src, logic [BASE_W-1:0] dst);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? CFG_SOURCE_BASE : CFG_TARGET_BASE;
			cfg_data  <= (i == 0) ? src : dst;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_src = src;
	endtask

	task automatic send_char(logic [7:0] c, logic last);
		while (idle_on && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_text(string txt);
		for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
	endtask

	// hold the sender until every result is back and the block has settled
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// numerals of random length, mostly valid digits of the current source base
	task automatic random_phase(int n_chars);
		int          sent;
		int          len;
		int          full_len;
		int          hi;
		logic [63:0] v;
		logic [7:0]  d;
		logic [7:0]  c;
		sent = 0;
		full_len = 8;
		if (cur_src >= 2) begin
			// digits of the largest value, to aim runs near the overflow edge
			v = 64'h7FFF_FFFF_FFFF_FFFF;
			full_len = 0;
			while (v != 0) begin
				v = v / 64'(cur_src);
				full_len++;
			end
		end
		hi = (cur_src > BASE_MAX) ? 35 : int'(cur_src) - 1;
		while (sent < n_chars) begin
			case ($urandom_range(9))
				0, 1: len = $urandom_range(full_len + 1, (full_len > 1) ? full_len - 1 : 1);
				2: len = $urandom_range(full_len, 1);
				default: len = $urandom_range(8, 1);
			endcase
			for (int i = 0; i < len; i++) begin
				if (hi < 0 || $urandom_range(99) < 10) begin
					c = 8'($urandom_range(255));
				end else begin
					d = 8'($urandom_range(hi));
					if (d < 8'(DEC_RADIX)) c = CHAR_0 + d;
					else c = (($urandom_range(1) != 0) ? CHAR_UA : CHAR_LA) + d - 8'(DEC_RADIX);
				end
				send_char(c, i == len - 1);
			end
			sent += len;
		end
	endtask

	// receiver: random back-pressure, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_on || ($urandom_range(99) >= 19);
			end
		end
	end

	initial begin
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SOURCE_BASE;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bases as left by reset
		send_text("0");
		send_text("255");
		send_text("1A3");          // letter not below the base; rest of the run ignored
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		drain();
		set_bases(BASE_MAX, BASE_MAX);
		send_text("zZzZzZzZzZzZz"); // 36^13 - 1 does not fit
		drain();

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: set_bases(6'd2, 6'd36);
				1: set_bases(6'd36, 6'd2);
				2: set_bases(6'd36, 6'd10);
				3: set_bases(6'd16, 6'd16);
				4: set_bases(6'd0, 6'd10);
				5: set_bases(6'd1, 6'd0);
				6: set_bases(6'd37, 6'd63);
				7: set_bases(6'd63, 6'd1);
				default: set_bases(BASE_W'($urandom_range(63)), BASE_W'($urandom_range(63)));
			endcase
			idle_on = (p != 3);
			// results back up while the sender keeps offering characters
			if (p == 2) hold_req = 1'b1;
			random_phase(CHARS_PER_PHASE);
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rsc_pkg.sv
src/rsc_ram.sv
src/rsc_datapath.sv
src/rsc_controller.sv
src/radix_string_converter_top.sv
src/rsc_checker.sv
tb/rsc_result_checker.sv
tb/tb_radix_string_converter_top.sv
